### hw/rtl/lpe_pkg.sv
// lpe_pkg: shared types and constants for the line position estimator
// no dependencies
`timescale 1ns / 1ps

package lpe_pkg;

    localparam int unsigned VAL_W = 7;
    localparam int unsigned POS_W = 11;
    localparam int unsigned WT_W  = 21;
    localparam int unsigned W_W   = 11;

    localparam logic [6:0]  FULL_SCALE = 7'd100;
    localparam logic [6:0]  FOUND_THR  = 7'd20;
    localparam logic [6:0]  WEIGHT_THR = 7'd8;
    localparam logic [10:0] POS_MAX    = 11'd1500;

    localparam logic OP_CAL  = 1'b0;
    localparam logic OP_MEAS = 1'b1;

    localparam logic REG_SENSOR_COUNT = 1'b0;
    localparam logic REG_WHITE_LINE   = 1'b1;

    typedef struct packed {
        logic       op;
        logic [3:0] sensor_index;
        logic [7:0] sample_value;
        logic       batch_first;
        logic       last_flag;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  out_index;
        logic [6:0]  calibrated_value;
        logic        frame_end;
        logic        line_found;
        logic [10:0] position;
    } out_item_t;

endpackage

### hw/rtl/line_position_estimator_core.sv
// line_position_estimator_core: calibration store, scaler and centroid for a line sensor array
// depends on lpe_pkg
`timescale 1ns / 1ps

// Takes one item per transfer and works on it alone. A calibration item passes through a
// memory read, an update and a write back and gives no result. A measurement item runs a
// 15-step restoring division for the scaling, which is skipped when the span is zero or the
// sample sits at or below the low bound. At frame end with a line found, a further 21-step
// division forms the centroid. Both divisions run on the one shared divider, one bit per
// cycle; output stalls can hold an item up further. Calibration bounds and batch extremes
// live in a single 16-entry memory (one word per sensor, read into a register when the item
// is taken); reset values of the bounds come from per-entry valid bits, so no clearing pass
// is needed. The next item is taken once the core is back in idle; a finished result waits
// in the last step until the output register is handed off or empty.
module line_position_estimator_core #(
    parameter int unsigned MAX_SENSORS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lpe_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lpe_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [4:0]          cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_SDIV, S_CDIV, S_DONE
    } state_t;

    // memory word: cal_high, cal_low, batch_high, batch_low
    typedef struct packed {
        logic [7:0] cal_high;
        logic [7:0] cal_low;
        logic [7:0] batch_high;
        logic [7:0] batch_low;
    } cal_word_t;

    cal_word_t cal_mem [16];
    cal_word_t rd_reg;
    logic      mem_we;
    cal_word_t mem_wdata;

    logic [15:0] cal_valid_reg;   // entry bounds written since reset

    state_t             state_reg;
    lpe_pkg::in_item_t  item_reg;
    logic [4:0]         count_reg;
    logic               white_reg;
    logic [20:0]        wsum_reg;
    logic [10:0]        wtot_reg;
    logic               seen_reg;
    logic [10:0]        last_pos_reg;

    // shared restoring divider
    logic [20:0] quo_reg;
    logic [11:0] rem_reg;
    logic [10:0] dvs_reg;
    logic [4:0]  step_reg;
    logic [6:0]  cv_reg;

    logic                out_valid_reg;
    lpe_pkg::out_item_t  out_reg;

    logic in_take;
    logic out_free;
    logic done_out;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    // last step of a measurement, where the output register is loaded
    assign done_out = (state_reg == S_DONE) && (step_reg == 5'd31);

    localparam logic [4:0] MAXS = 5'(MAX_SENSORS);
    logic idx_ok;
    assign idx_ok = ({1'b0, in_data.sensor_index} < MAXS);

    // effective bounds (reset value until the entry is written)
    logic [7:0] eff_hi, eff_lo, eff_bh, eff_bl;
    always_comb
    begin
        eff_hi = cal_valid_reg[item_reg.sensor_index] ? rd_reg.cal_high : 8'd0;
        eff_lo = cal_valid_reg[item_reg.sensor_index] ? rd_reg.cal_low  : 8'd255;
        eff_bh = cal_valid_reg[item_reg.sensor_index] ? rd_reg.batch_high : 8'd0;
        eff_bl = cal_valid_reg[item_reg.sensor_index] ? rd_reg.batch_low  : 8'd0;
    end

    // calibration update
    logic [7:0] nbh, nbl, nch, ncl;
    always_comb
    begin
        if (item_reg.batch_first)
        begin
            nbh = item_reg.sample_value;
            nbl = item_reg.sample_value;
        end
        else
        begin
            nbh = (item_reg.sample_value > eff_bh) ? item_reg.sample_value : eff_bh;
            nbl = (item_reg.sample_value < eff_bl) ? item_reg.sample_value : eff_bl;
        end
        nch = eff_hi;
        ncl = eff_lo;
        if (item_reg.last_flag)
        begin
            if (nbl > eff_hi) nch = nbl;
            if (nbh < eff_lo) ncl = nbh;
        end
        mem_wdata = '{cal_high: nch, cal_low: ncl, batch_high: nbh, batch_low: nbl};
        mem_we    = (state_reg == S_EXEC) && (item_reg.op == lpe_pkg::OP_CAL);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cal_mem[item_reg.sensor_index] <= mem_wdata;
        if (in_take)
            rd_reg <= cal_mem[in_data.sensor_index];
    end

    // scaled value and accumulate terms
    logic [7:0]  den;
    logic [6:0]  cv_clamp;
    logic [6:0]  val;
    logic [13:0] prod_vi;
    logic [20:0] term;
    logic [21:0] wsum_add;
    logic [11:0] wtot_add;
    always_comb
    begin
        den      = eff_hi - eff_lo;
        // full quotient can reach 25500 when the span is narrow
        cv_clamp = (quo_reg > 21'd100) ? lpe_pkg::FULL_SCALE : quo_reg[6:0];
        val      = white_reg ? (lpe_pkg::FULL_SCALE - cv_reg) : cv_reg;
        prod_vi  = 14'(val) * 14'(item_reg.sensor_index);
        term     = 21'(prod_vi) * 21'd100;
        wsum_add = {1'b0, wsum_reg} + {1'b0, term};
        wtot_add = {1'b0, wtot_reg} + 12'(val);
    end

    logic [4:0]  n_clamp;
    logic [10:0] span;
    always_comb
    begin
        n_clamp = (count_reg == 5'd0) ? 5'd1 : ((count_reg > MAXS) ? MAXS : count_reg);
        span    = 11'(11'(n_clamp - 5'd1) * 11'd100);
    end

    // divider step
    logic [11:0] rem_sh;
    logic        ge;
    always_comb
    begin
        rem_sh = {rem_reg[10:0], quo_reg[20]};
        ge     = (rem_sh >= {1'b0, dvs_reg});
    end

    logic [10:0] cpos;
    assign cpos = (quo_reg[10:0] > lpe_pkg::POS_MAX || quo_reg[20:11] != '0)
                  ? lpe_pkg::POS_MAX : quo_reg[10:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cal_valid_reg <= '0;
            count_reg     <= 5'd8;
            white_reg     <= 1'b0;
            wsum_reg      <= '0;
            wtot_reg      <= '0;
            seen_reg      <= 1'b0;
            last_pos_reg  <= '0;
            step_reg      <= 5'd31;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == lpe_pkg::REG_SENSOR_COUNT) count_reg <= cfg_data;
                else white_reg <= cfg_data[0];
            end
            if (out_valid_reg && !out_stall && !done_out)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take && idx_ok)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_EXEC;
                S_EXEC:
                begin
                    if (item_reg.op == lpe_pkg::OP_CAL)
                    begin
                        cal_valid_reg[item_reg.sensor_index] <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (den == 8'd0 || item_reg.sample_value <= eff_lo)
                    begin
                        cv_reg    <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        // dividend (v-lo)*100 fits 15 bits, placed at top of quotient
                        quo_reg   <= {6'(0), 15'(15'(item_reg.sample_value - eff_lo)
                                                 * 15'd100)} << 6;
                        rem_reg   <= '0;
                        dvs_reg   <= {3'd0, den};
                        step_reg  <= 5'd15;
                        state_reg <= S_SDIV;
                    end
                end
                S_SDIV:
                begin
                    rem_reg  <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                    quo_reg  <= {quo_reg[19:0], ge};
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd1)
                        state_reg <= S_DONE;
                    if (step_reg == 5'd0)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // first pass: latch the divided value if any; final pass: accumulate, emit or start centroid
                    if (step_reg != 5'd31)
                    begin
                        if (!(den == 8'd0 || item_reg.sample_value <= eff_lo))
                            cv_reg <= cv_clamp;
                        step_reg <= 5'd31;
                    end
                    else if (out_free)
                    begin
                        logic [20:0] ws;
                        logic [10:0] wt;
                        logic        sn;
                        ws = wsum_reg;
                        wt = wtot_reg;
                        sn = seen_reg || (val > lpe_pkg::FOUND_THR);
                        if (val > lpe_pkg::WEIGHT_THR)
                        begin
                            ws = wsum_add[21] ? '1 : wsum_add[20:0];
                            wt = wtot_add[11] ? '1 : wtot_add[10:0];
                        end
                        out_reg.out_index        <= item_reg.sensor_index;
                        out_reg.calibrated_value <= cv_reg;
                        out_reg.frame_end        <= item_reg.last_flag;
                        out_reg.line_found       <= item_reg.last_flag && sn;
                        if (!item_reg.last_flag)
                        begin
                            out_reg.position <= '0;
                            wsum_reg      <= ws;
                            wtot_reg      <= wt;
                            seen_reg      <= sn;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else if (sn && wt != '0)
                        begin
                            out_valid_reg <= 1'b0;
                            quo_reg   <= ws;
                            rem_reg   <= '0;
                            dvs_reg   <= wt;
                            step_reg  <= 5'd21;
                            state_reg <= S_CDIV;
                        end
                        else
                        begin
                            out_reg.position <= (last_pos_reg < (span >> 1)) ? '0 : span;
                            wsum_reg      <= '0;
                            wtot_reg      <= '0;
                            seen_reg      <= 1'b0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_CDIV:
                begin
                    if (step_reg != 5'd0)
                    begin
                        rem_reg  <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                        quo_reg  <= {quo_reg[19:0], ge};
                        step_reg <= step_reg - 5'd1;
                    end
                    else
                    begin
                        out_reg.position <= cpos;
                        last_pos_reg     <= cpos;
                        wsum_reg         <= '0;
                        wtot_reg         <= '0;
                        seen_reg         <= 1'b0;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a result never appears while the block is still working on an item
    a_out_only_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> state_reg == S_IDLE)
        else $error("result raised outside idle");

    // a held result keeps its payload while the consumer stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("stalled result changed");

    // stored position never exceeds full scale
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_pos_reg <= lpe_pkg::POS_MAX)
        else $error("last position out of range");
`endif

endmodule

### bench/line_position_estimator_core_tb.sv
// line_position_estimator_core_tb: self-checking bench for the line position estimator core
// depends on lpe_pkg and line_position_estimator_core
`timescale 1ns / 1ps

module line_position_estimator_core_tb;

    localparam int unsigned NSENS = 16;
    localparam int unsigned DRAIN_CYCLES = 60;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    lpe_pkg::in_item_t   in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    lpe_pkg::out_item_t  out_data;
    logic                cfg_we = 1'b0;
    logic                cfg_index = lpe_pkg::REG_SENSOR_COUNT;
    logic [4:0]          cfg_data = '0;

    // predictor state
    logic [4:0]  sensor_count_q;
    logic        white_line_q;
    logic [7:0]  cal_high_q [NSENS];
    logic [7:0]  cal_low_q [NSENS];
    logic [7:0]  batch_high_q [NSENS];
    logic [7:0]  batch_low_q [NSENS];
    bit          batch_started [NSENS];
    int unsigned weighted_sum;
    int unsigned weight_sum;
    bit          line_seen;
    int unsigned prev_position;

    lpe_pkg::out_item_t  expected_results [$];
    int          error_count = 0;
    bit          idle_enable = 1'b0;
    bit          hold_receiver = 1'b0;
    int          stall_left = 0;

    line_position_estimator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        #20ms;
        $display("line_position_estimator_core_tb NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic logic [6:0] scale_reading(input logic [3:0] idx, input logic [7:0] v);
        logic [7:0]  den;
        int unsigned q;
        den = cal_high_q[idx] - cal_low_q[idx];
        if (den == 0 || v <= cal_low_q[idx])
            return 7'd0;
        q = (int'(v) - int'(cal_low_q[idx])) * 100 / int'(den);
        return (q > 100) ? 7'd100 : 7'(q);
    endfunction

    // update the predictor for one accepted item, queueing its result if any
    task automatic predict_item(input lpe_pkg::in_item_t it);
        logic [3:0]          idx;
        logic [6:0]          cv;
        int unsigned         val, n, span;
        lpe_pkg::out_item_t  r;
        idx = it.sensor_index;
        if (it.op == lpe_pkg::OP_CAL)
        begin
            if (it.batch_first)
            begin
                batch_high_q[idx] = it.sample_value;
                batch_low_q[idx] = it.sample_value;
                batch_started[idx] = 1'b1;
            end
            else
            begin
                if (it.sample_value > batch_high_q[idx]) batch_high_q[idx] = it.sample_value;
                if (it.sample_value < batch_low_q[idx]) batch_low_q[idx] = it.sample_value;
            end
            if (it.last_flag)
            begin
                if (batch_low_q[idx] > cal_high_q[idx]) cal_high_q[idx] = batch_low_q[idx];
                if (batch_high_q[idx] < cal_low_q[idx]) cal_low_q[idx] = batch_high_q[idx];
            end
            return;
        end
        cv = scale_reading(idx, it.sample_value);
        val = white_line_q ? 100 - cv : cv;
        if (val > 20) line_seen = 1'b1;
        if (val > 8)
        begin
            weighted_sum += val * idx * 100;
            weight_sum += val;
            if (weighted_sum > 21'h1FFFFF) weighted_sum = 21'h1FFFFF;
            if (weight_sum > 11'h7FF) weight_sum = 11'h7FF;
        end
        r = '0;
        r.out_index = idx;
        r.calibrated_value = cv;
        r.frame_end = it.last_flag;
        if (it.last_flag)
        begin
            n = sensor_count_q;
            if (n < 1) n = 1;
            if (n > NSENS) n = NSENS;
            r.line_found = line_seen;
            if (line_seen && weight_sum != 0)
            begin
                val = weighted_sum / weight_sum;
                if (val > 1500) val = 1500;
                prev_position = val;
                r.position = 11'(val);
            end
            else
            begin
                span = (n - 1) * 100;
                r.position = (prev_position < span / 2) ? 11'd0 : 11'(span);
            end
            weighted_sum = 0;
            weight_sum = 0;
            line_seen = 1'b0;
        end
        expected_results.push_back(r);
    endtask

    // sender idles between transfers in random bursts
    task automatic send_item(input lpe_pkg::in_item_t it);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_item(it);
    endtask

    function automatic lpe_pkg::in_item_t make_item(input logic op, input logic [3:0] idx,
                                                    input logic [7:0] v, input logic first,
                                                    input logic last);
        lpe_pkg::in_item_t it;
        it.op = op;
        it.sensor_index = idx;
        it.sample_value = v;
        it.batch_first = first;
        it.last_flag = last;
        return it;
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [4:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lpe_pkg::REG_SENSOR_COUNT) sensor_count_q = value;
        else white_line_q = value[0];
    endtask

    // receiver: random stall bursts, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_receiver)
            out_stall <= 1'b1;
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end
        else
            out_stall <= 1'b0;
    end

    // result checker, compares every transfer against the oldest expectation
    always @(posedge clk)
    begin
        lpe_pkg::out_item_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                w = expected_results.pop_front();
                if (out_data.out_index != w.out_index)
                    report_mismatch("out_index", out_data.out_index, w.out_index);
                if (out_data.calibrated_value != w.calibrated_value)
                    report_mismatch("calibrated_value", out_data.calibrated_value,
                                    w.calibrated_value);
                if (out_data.frame_end != w.frame_end)
                    report_mismatch("frame_end", out_data.frame_end, w.frame_end);
                if (out_data.line_found != w.line_found)
                    report_mismatch("line_found", out_data.line_found, w.line_found);
                if (out_data.position != w.position)
                    report_mismatch("position", out_data.position, w.position);
            end
        end
    end

    // one calibration batch of k reads for a sensor, values around lo..hi
    task automatic calibrate_sensor(input logic [3:0] idx, input int k,
                                    input int lo, input int hi);
        for (int i = 0; i < k; i++)
            send_item(make_item(lpe_pkg::OP_CAL, idx, 8'($urandom_range(lo, hi)),
                                i == 0, i == k - 1));
    endtask

    task automatic test_directed();
        // measurement before any calibration: samples at or below the reset low bound
        send_item(make_item(lpe_pkg::OP_MEAS, 4'd0, 8'd255, 1'b0, 1'b0));
        send_item(make_item(lpe_pkg::OP_MEAS, 4'd15, 8'd0, 1'b0, 1'b1));
        // single-item batches set both bounds at the extremes
        send_item(make_item(lpe_pkg::OP_CAL, 4'd0, 8'd0, 1'b1, 1'b1));
        send_item(make_item(lpe_pkg::OP_CAL, 4'd0, 8'd255, 1'b1, 1'b1));
        send_item(make_item(lpe_pkg::OP_CAL, 4'd15, 8'd10, 1'b1, 1'b0));
        send_item(make_item(lpe_pkg::OP_CAL, 4'd15, 8'd250, 1'b0, 1'b0));
        send_item(make_item(lpe_pkg::OP_CAL, 4'd15, 8'd5, 1'b0, 1'b1));
        send_item(make_item(lpe_pkg::OP_CAL, 4'd15, 8'd245, 1'b1, 1'b1));
        send_item(make_item(lpe_pkg::OP_MEAS, 4'd0, 8'd0, 1'b0, 1'b0));
        send_item(make_item(lpe_pkg::OP_MEAS, 4'd0, 8'd255, 1'b0, 1'b0));
        send_item(make_item(lpe_pkg::OP_MEAS, 4'd15, 8'd5, 1'b0, 1'b0));
        send_item(make_item(lpe_pkg::OP_MEAS, 4'd15, 8'd130, 1'b0, 1'b0));
        send_item(make_item(lpe_pkg::OP_MEAS, 4'd15, 8'd255, 1'b0, 1'b1));
        // frame with nothing found: edge fallback
        send_item(make_item(lpe_pkg::OP_MEAS, 4'd0, 8'd0, 1'b0, 1'b1));
        // repeated reads of sensor 15, whose span is zero here, so the accumulators stay empty
        for (int i = 0; i < 10; i++)
            send_item(make_item(lpe_pkg::OP_MEAS, 4'd15, 8'd255, 1'b0, i == 9));
    endtask

    task automatic random_frames(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                for (int s = 0; s < NSENS; s++)
                    if ($urandom_range(0, 3) == 0 || !batch_started[s])
                    begin
                        n = $urandom_range(1, 4);
                        calibrate_sensor(4'(s), n, $urandom_range(0, 120),
                                         $urandom_range(130, 255));
                        sent += n;
                    end
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                // noise: stray calibration items, batch continuations and random batch ends
                for (int i = 0; i < 4; i++)
                begin
                    n = $urandom_range(0, 15);
                    send_item(make_item(lpe_pkg::OP_CAL, 4'(n), 8'($urandom),
                                        !batch_started[n] || $urandom_range(0, 1),
                                        1'($urandom)));
                end
                sent += 4;
            end
            else
            begin
                n = $urandom_range(1, 16);
                for (int s = 0; s < n; s++)
                    send_item(make_item(lpe_pkg::OP_MEAS,
                        ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'(s),
                        8'($urandom), 1'($urandom), s == n - 1));
                sent += n;
            end
        end
    endtask

    task automatic test_configs();
        write_register(lpe_pkg::REG_SENSOR_COUNT, 5'd1);
        write_register(lpe_pkg::REG_WHITE_LINE, 5'd0);
        random_frames(250);
        write_register(lpe_pkg::REG_SENSOR_COUNT, 5'd16);
        random_frames(250);
        write_register(lpe_pkg::REG_WHITE_LINE, 5'd1);
        random_frames(250);
        write_register(lpe_pkg::REG_SENSOR_COUNT, 5'd0);
        random_frames(150);
        write_register(lpe_pkg::REG_SENSOR_COUNT, 5'd31);
        random_frames(150);
        write_register(lpe_pkg::REG_SENSOR_COUNT, 5'($urandom_range(2, 15)));
        write_register(lpe_pkg::REG_WHITE_LINE, 5'd0);
        random_frames(300);
    endtask

    task automatic test_backpressure();
        int k;
        fork
            begin
                hold_receiver = 1'b1;
                k = 0;
                while (k < 400)
                begin
                    @(posedge clk);
                    k++;
                end
                hold_receiver = 1'b0;
            end
            begin
                random_frames(40);
                in_valid <= 1'b0;
                @(posedge clk);
            end
        join
    endtask

    initial
    begin
        sensor_count_q = 5'd8;
        white_line_q = 1'b0;
        for (int s = 0; s < NSENS; s++)
        begin
            cal_high_q[s] = 8'd0;
            cal_low_q[s] = 8'd255;
            batch_high_q[s] = 8'd0;
            batch_low_q[s] = 8'd0;
            batch_started[s] = 1'b0;
        end
        weighted_sum = 0;
        weight_sum = 0;
        line_seen = 1'b0;
        prev_position = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        idle_enable = 1'b1;
        test_configs();
        test_backpressure();
        // final stretch without idling
        idle_enable = 1'b0;
        random_frames(400);
        wait_idle();
        if (error_count == 0)
            $display("line_position_estimator_core_tb OK");
        else
            $display("line_position_estimator_core_tb NOT OK");
        $finish;
    end

endmodule

### files.f
hw/rtl/lpe_pkg.sv
hw/rtl/line_position_estimator_core.sv
bench/line_position_estimator_core_tb.sv
